/* src/dbcs_pkg.sv */
// dbcs_pkg: shared types, codes and helpers of the decimal blink-code sequencer
// no dependencies; imported by dbcs_digit_split and the top level
package dbcs_pkg;

  // width of the millisecond down-counter
  localparam int unsigned TIMER_BITS = 16;

  // input operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_ABORT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_BLINK_LEVEL  = 3'd0,
    CFG_LONG_ON_MS   = 3'd1,
    CFG_SHORT_ON_MS  = 3'd2,
    CFG_OFF_MS       = 3'd3,
    CFG_DIGIT_GAP_MS = 3'd4,
    CFG_END_PAUSE_MS = 3'd5
  } cfg_idx_t;

  // sequence phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ON    = 3'd1,
    PH_OFF   = 3'd2,
    PH_GAP   = 3'd3,
    PH_PAUSE = 3'd4
  } phase_t;

  // decimal split of one value
  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [1:0] first_slot;
  } digits_t;

  // loads a duration into the timer, saturating at the counter maximum
  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] ms);
    logic [32:0] wide;
    logic [32:0] lim;
    wide = {17'd0, ms};
    lim  = (33'd1 << TIMER_BITS) - 33'd1;
    if (wide > lim) begin
      timer_load = lim[TIMER_BITS-1:0];
    end else begin
      timer_load = wide[TIMER_BITS-1:0];
    end
  endfunction

endpackage

/* src/dbcs_digit_split.sv */
// dbcs_digit_split: splits an 8-bit value into hundreds, tens and ones
// depends on dbcs_pkg (digits_t)
module dbcs_digit_split (
  input  logic [7:0]        value,
  output dbcs_pkg::digits_t digits
);
  import dbcs_pkg::*;

  logic [13:0] h_prod;
  logic [1:0]  hund;
  logic [7:0]  h_x100;
  logic [6:0]  rem;
  logic [14:0] t_prod;
  logic [3:0]  tens;
  logic [6:0]  t_x10;
  logic [6:0]  ones_w;

  // x / 100 == (x * 41) >> 12 for x below 256
  assign h_prod = {6'd0, value} * 14'd41;
  assign hund   = h_prod[13:12];
  assign h_x100 = {6'd0, hund} * 8'd100;
  assign rem    = 7'(value - h_x100);
  // r / 10 == (r * 205) >> 11 for r below 100
  assign t_prod = {8'd0, rem} * 15'd205;
  assign tens   = t_prod[14:11];
  assign t_x10  = {3'd0, tens} * 7'd10;
  assign ones_w = rem - t_x10;

  always_comb begin
    digits.hundreds = {2'd0, hund};
    digits.tens     = tens;
    digits.ones     = ones_w[3:0];
    if (hund != 2'd0) begin
      digits.first_slot = 2'd0;
    end else if (tens != 4'd0) begin
      digits.first_slot = 2'd1;
    end else begin
      digits.first_slot = 2'd2;
    end
  end

endmodule

/* src/decimal_blink_code_sequencer.sv */
// decimal_blink_code_sequencer: top level, blinks an 8-bit number as decimal digits
// depends on dbcs_pkg and dbcs_digit_split
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------------
//  input   | in_valid / in_stall      | operation[1:0], value[7:0]
//  output  | out_valid / out_stall    | level[7:0], busy_res, done_res, aborted
//  config  | cfg_we (no wait)         | cfg_index[2:0], cfg_data[15:0]
//
// each input word is handled as it is accepted: the phase and timer update is done in the
// same cycle the word is accepted and its result word is registered at that edge
// a new word can be accepted every cycle; the single output register is the only
// place a result waits, so input stalls only while that register is full and stalled
// reset (rst, synchronous) returns the config registers to their defaults and the
// sequence to idle with the held level at zero; of the result register only out_valid is reset
module decimal_blink_code_sequencer (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  value,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  level,
  output logic        busy_res,
  output logic        done_res,
  output logic        aborted,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dbcs_pkg::*;

  // configuration registers
  logic [7:0]  blink_level;
  logic [15:0] long_on_ms;
  logic [15:0] short_on_ms;
  logic [15:0] off_ms;
  logic [15:0] digit_gap_ms;
  logic [15:0] end_pause_ms;

  // sequence state
  phase_t                phase, phase_next;
  logic [1:0]            digit_slot, digit_slot_next;
  logic [3:0]            digit_store [3];
  logic [3:0]            digit_store_next [3];
  logic [3:0]            blinks_left, blinks_left_next;
  logic [TIMER_BITS-1:0] ms_left, ms_left_next;
  logic [7:0]            level_now, level_now_next;

  // per-word control
  logic    accept_in;
  op_t     op;
  digits_t split;
  logic    expired;
  logic [3:0] blinks_dec;
  logic [3:0] next_digit;
  logic [1:0] slot_inc;
  logic    done_now;
  logic    abort_now;

  assign accept_in = in_valid & ~in_stall;
  // stall only while the result register is full and not being drained
  assign in_stall  = out_valid & out_stall;
  assign op        = op_t'(operation);

  dbcs_digit_split u_split (
    .value  (value),
    .digits (split)
  );

  // timer runs out on this tick when one (or zero) ms remains
  assign expired    = (ms_left <= TIMER_BITS'(1));
  assign blinks_dec = (blinks_left != 4'd0) ? 4'(blinks_left - 4'd1) : 4'd0;
  assign slot_inc   = 2'(digit_slot + 2'd1);

  // digit that follows the current slot, for the step out of the digit gap
  always_comb begin
    case (slot_inc)
      2'd1:    next_digit = digit_store[1];
      2'd2:    next_digit = digit_store[2];
      default: next_digit = digit_store[0];
    endcase
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept_in) begin
      case (op)
        OP_TICK: begin
          if (expired) begin
            case (phase)
              PH_ON:    phase_next = PH_OFF;
              PH_OFF:   phase_next = (blinks_dec != 4'd0) ? PH_ON : PH_GAP;
              PH_GAP:   phase_next = (digit_slot < 2'd2) ? PH_ON : PH_PAUSE;
              PH_PAUSE: phase_next = PH_IDLE;
              default:  phase_next = PH_IDLE;
            endcase
          end
        end
        OP_START: phase_next = PH_ON;
        OP_ABORT: phase_next = PH_IDLE;
        default:  phase_next = phase;
      endcase
    end
  end

  // datapath and result flags
  always_comb begin
    digit_slot_next     = digit_slot;
    digit_store_next[0] = digit_store[0];
    digit_store_next[1] = digit_store[1];
    digit_store_next[2] = digit_store[2];
    blinks_left_next    = blinks_left;
    ms_left_next        = ms_left;
    level_now_next      = level_now;
    done_now            = 1'b0;
    abort_now           = 1'b0;
    if (accept_in) begin
      case (op)
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            if (!expired) begin
              ms_left_next = ms_left - TIMER_BITS'(1);
            end else begin
              ms_left_next = '0;
              case (phase)
                PH_ON: begin
                  level_now_next = 8'd0;
                  ms_left_next   = timer_load(off_ms);
                end
                PH_OFF: begin
                  blinks_left_next = blinks_dec;
                  if (blinks_dec != 4'd0) begin
                    level_now_next = blink_level;
                    ms_left_next   = timer_load(long_on_ms);
                  end else begin
                    ms_left_next   = timer_load(digit_gap_ms);
                  end
                end
                PH_GAP: begin
                  if (digit_slot < 2'd2) begin
                    // begin the next digit: a zero digit is one short blink
                    digit_slot_next = slot_inc;
                    level_now_next  = blink_level;
                    if (next_digit == 4'd0) begin
                      blinks_left_next = 4'd1;
                      ms_left_next     = timer_load(short_on_ms);
                    end else begin
                      blinks_left_next = next_digit;
                      ms_left_next     = timer_load(long_on_ms);
                    end
                  end else begin
                    ms_left_next = timer_load(end_pause_ms);
                  end
                end
                default: begin
                  // final pause done
                  done_now = 1'b1;
                end
              endcase
            end
          end
        end
        OP_START: begin
          // restart at once from the first nonzero digit (ones always shown)
          digit_store_next[0] = split.hundreds;
          digit_store_next[1] = split.tens;
          digit_store_next[2] = split.ones;
          digit_slot_next     = split.first_slot;
          level_now_next      = blink_level;
          case (split.first_slot)
            2'd0: begin
              blinks_left_next = split.hundreds;
              ms_left_next     = timer_load(long_on_ms);
            end
            2'd1: begin
              blinks_left_next = split.tens;
              ms_left_next     = timer_load(long_on_ms);
            end
            default: begin
              if (split.ones == 4'd0) begin
                blinks_left_next = 4'd1;
                ms_left_next     = timer_load(short_on_ms);
              end else begin
                blinks_left_next = split.ones;
                ms_left_next     = timer_load(long_on_ms);
              end
            end
          endcase
        end
        OP_ABORT: begin
          // level is left as it was, even mid-blink
          if (phase != PH_IDLE) begin
            ms_left_next     = '0;
            blinks_left_next = 4'd0;
            abort_now        = 1'b1;
          end
        end
        default: begin
          // unused code: result only reports the state
        end
      endcase
    end
  end

  // configuration registers; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_level  <= 8'd255;
      long_on_ms   <= 16'd200;
      short_on_ms  <= 16'd8;
      off_ms       <= 16'd400;
      digit_gap_ms <= 16'd600;
      end_pause_ms <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BLINK_LEVEL:  blink_level  <= cfg_data[7:0];
        CFG_LONG_ON_MS:   long_on_ms   <= cfg_data;
        CFG_SHORT_ON_MS:  short_on_ms  <= cfg_data;
        CFG_OFF_MS:       off_ms       <= cfg_data;
        CFG_DIGIT_GAP_MS: digit_gap_ms <= cfg_data;
        CFG_END_PAUSE_MS: end_pause_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      digit_slot     <= 2'd0;
      digit_store[0] <= 4'd0;
      digit_store[1] <= 4'd0;
      digit_store[2] <= 4'd0;
      blinks_left    <= 4'd0;
      ms_left        <= '0;
      level_now      <= 8'd0;
    end else begin
      phase          <= phase_next;
      digit_slot     <= digit_slot_next;
      digit_store[0] <= digit_store_next[0];
      digit_store[1] <= digit_store_next[1];
      digit_store[2] <= digit_store_next[2];
      blinks_left    <= blinks_left_next;
      ms_left        <= ms_left_next;
      level_now      <= level_now_next;
    end
  end

  // result register: loads on every accepted word, holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept_in) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      level    <= level_now_next;
      busy_res <= (phase_next != PH_IDLE);
      done_res <= done_now;
      aborted  <= abort_now;
    end
  end

endmodule

/* src/dbcs_checker.sv */
// dbcs_checker: port-level checks of the decimal blink-code sequencer
// depends on the top level's ports only; bound to it below
module dbcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] operation,
  input logic [7:0] value,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] level,
  input logic       busy_res,
  input logic       done_res,
  input logic       aborted
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level) && $stable(busy_res)
      && $stable(done_res) && $stable(aborted))
    else $error("stalled result word changed");

  // input is held back only by a full, stalled result register
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result register can take a word");

  // a sequence cannot both finish and be aborted on one word
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && aborted))
    else $error("done and aborted together");

  // finishing leaves the block idle and dark
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && (level == 8'd0))
    else $error("done while still busy or lit");

  // an abort leaves the block idle
  a_abort_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && aborted |-> !busy_res)
    else $error("aborted while still busy");

endmodule

bind decimal_blink_code_sequencer dbcs_checker u_dbcs_checker (.*);
